// ===== rtl/sssd_pkg.sv =====
// shared types, codes and segment decode for the seven-segment scan driver
package sssd_pkg;

  // action codes carried by an input transaction
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_NUMBER = 2'd1;
  localparam logic [1:0] ACT_ERROR  = 2'd2;

  // digit codes beyond the decimal digits
  localparam logic [3:0] CODE_E     = 4'd10;
  localparam logic [3:0] CODE_R     = 4'd11;
  localparam logic [3:0] CODE_MINUS = 4'd12;
  localparam logic [3:0] CODE_BLANK = 4'd15;

  localparam int unsigned NumDigits = 4;
  localparam logic [13:0] MaxValue  = 14'd9999;

  // one code per digit position, position 0 rightmost
  typedef logic [NumDigits-1:0][3:0] digits_t;

  // segments a..g in bits 0..6, 1 lit
  function automatic logic [6:0] seg_decode(input logic [3:0] code);
    logic [6:0] seg;
    case (code)
      4'd0:       seg = 7'h3F;
      4'd1:       seg = 7'h06;
      4'd2:       seg = 7'h5B;
      4'd3:       seg = 7'h4F;
      4'd4:       seg = 7'h66;
      4'd5:       seg = 7'h6D;
      4'd6:       seg = 7'h7D;
      4'd7:       seg = 7'h27;
      4'd8:       seg = 7'h7F;
      4'd9:       seg = 7'h6F;
      CODE_E:     seg = 7'h79;
      CODE_R:     seg = 7'h50;
      CODE_MINUS: seg = 7'h40;
      default:    seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

// ===== rtl/sssd_digit_split.sv =====
// binary to four decimal digits: compare-and-subtract steps for thousands, hundreds and tens, units left over
module sssd_digit_split import sssd_pkg::*; (
  input  logic [13:0] value_i,
  output digits_t     digits_o
);

  logic [13:0] v_clamp;
  logic [3:0]  d3, d2, d1;
  logic [9:0]  r1;
  logic [6:0]  r2;
  logic [3:0]  r3;

  always_comb begin
    v_clamp = (value_i > MaxValue) ? MaxValue : value_i;

    // thousands: count thresholds passed, independent compares
    d3 = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v_clamp >= 14'(k * 1000)) d3 = 4'(k);
    end
    r1 = 10'(v_clamp - 14'(d3) * 14'd1000);

    // hundreds
    d2 = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r1 >= 10'(k * 100)) d2 = 4'(k);
    end
    r2 = 7'(r1 - 10'(d2) * 10'd100);

    // tens and units
    d1 = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r2 >= 7'(k * 10)) d1 = 4'(k);
    end
    r3 = 4'(r2 - 7'(d1) * 7'd10);

    digits_o = {d3, d2, d1, r3};
  end

endmodule

// ===== rtl/seven_segment_scan_driver.sv =====
// top level of the four-digit multiplexed seven-segment scan driver
// the block takes one input transaction per cycle and gives at most one result
// transaction per input. a set-number transaction (clamped to 9999) is split into
// four decimal digits plus a minus flag, and is dropped while an error is held.
// a set-error transaction holds the code and loads E r r code (code zero releases
// the hold). each scan tick gives one result: the one-hot enable of the current
// position, its segment pattern and its decimal point, then moves to the next
// position. digit 1 carries the point unless an error is held; leading zeros
// are blanked on digits 3 and 2; digit 3 shows minus when the flag is set and no
// error is held. a tick goes from the input register into the result register,
// which holds it until the sink takes it. throughput is one transaction per
// cycle, limited only by the result register while the sink stalls; a set
// transaction in the input register never waits on the sink, but one that
// arrives behind a stalled tick waits until that tick moves on.
module seven_segment_scan_driver import sssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [13:0] value_i,
  input  logic        negative_i,
  input  logic [3:0]  error_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  digit_enable_o,
  output logic [6:0]  segments_o,
  output logic        point_o
);

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic [1:0]  s1_action_q;
  logic [13:0] s1_value_q;
  logic        s1_neg_q;
  logic [3:0]  s1_ecode_q;

  // display state
  digits_t     digits_q, digits_d;
  logic [3:0]  held_error_q, held_error_d;
  logic        minus_q, minus_d;
  logic [1:0]  pos_q, pos_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [3:0]  enable_q, enable_d;
  logic [6:0]  seg_q, seg_d;
  logic        point_q, point_d;

  logic        s1_fire;
  logic        in_fire;
  logic        err;
  logic [3:0]  code;
  logic        dot;
  digits_t     split_digits;

  // decimal split of the registered value
  sssd_digit_split u_split (
    .value_i  (s1_value_q),
    .digits_o (split_digits)
  );

  // a tick needs room in the result register, set transactions never wait
  assign s1_fire    = s1_valid_q &&
                      ((s1_action_q != ACT_TICK) || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;
  assign err        = (held_error_q != 4'd0);

  always_comb begin
    s1_valid_d   = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    digits_d     = digits_q;
    held_error_d = held_error_q;
    minus_d      = minus_q;
    pos_d        = pos_q;
    out_valid_d  = (out_valid_q && !out_ready_i) ? 1'b1 : 1'b0;
    enable_d     = enable_q;
    seg_d        = seg_q;
    point_d      = point_q;

    // pick what the current position shows
    dot = 1'b0;
    case (pos_q)
      2'd0: code = digits_q[0];
      2'd1: begin
        code = digits_q[1];
        dot  = !err;
      end
      2'd2: begin
        code = ((digits_q[3] == 4'd0) && (digits_q[2] == 4'd0)) ? CODE_BLANK : digits_q[2];
      end
      default: begin
        if (minus_q && !err) code = CODE_MINUS;
        else if (digits_q[3] == 4'd0) code = CODE_BLANK;
        else code = digits_q[3];
      end
    endcase

    if (s1_fire) begin
      case (s1_action_q)
        ACT_TICK: begin
          out_valid_d = 1'b1;
          enable_d    = 4'b0001 << pos_q;
          seg_d       = seg_decode(code);
          point_d     = dot;
          pos_d       = pos_q + 2'd1;
        end
        ACT_NUMBER: begin
          // ignored while an error is held
          if (!err) begin
            digits_d = split_digits;
            minus_d  = s1_neg_q;
          end
        end
        ACT_ERROR: begin
          held_error_d = s1_ecode_q;
          digits_d[3]  = CODE_E;
          digits_d[2]  = CODE_R;
          digits_d[1]  = CODE_R;
          digits_d[0]  = (s1_ecode_q <= 4'd9) ? s1_ecode_q : CODE_BLANK;
        end
        default: ; // unused action, dropped without a result
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      digits_q     <= '0;
      held_error_q <= 4'd0;
      minus_q      <= 1'b0;
      pos_q        <= 2'd0;
      out_valid_q  <= 1'b0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      digits_q     <= digits_d;
      held_error_q <= held_error_d;
      minus_q      <= minus_d;
      pos_q        <= pos_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= action_i;
      s1_value_q  <= value_i;
      s1_neg_q    <= negative_i;
      s1_ecode_q  <= error_code_i;
    end
    enable_q <= enable_d;
    seg_q    <= seg_d;
    point_q  <= point_d;
  end

  assign out_valid_o    = out_valid_q;
  assign digit_enable_o = enable_q;
  assign segments_o     = seg_q;
  assign point_o        = point_q;

  // a result always selects exactly one digit
  a_onehot_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot(digit_enable_o))
    else $error("digit enable not one-hot");

  // the point only ever appears on digit 1
  a_point_digit1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && point_o) |-> (digit_enable_o == 4'b0010))
    else $error("point on wrong digit");

  // a set-number transaction leaves the digits alone while an error is held
  a_error_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && (s1_action_q == ACT_NUMBER) && err) |=> $stable(digits_q))
    else $error("digits changed under error hold");

  // the scan position moves only on a tick that produces a result
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_fire && (s1_action_q == ACT_TICK)) |=> $stable(pos_q))
    else $error("scan position moved without a tick");

endmodule

// ===== test/tb.sv =====
// testbench for the four-digit seven-segment scan driver
`timescale 1ns / 100ps

module tb;
  import sssd_pkg::*;

  // one scan result as the display lines show it
  typedef struct packed {
    logic [3:0] enable;
    logic [6:0] segments;
    logic       point;
  } scan_lines_t;

  // display state mirror and the queue of scan lines still to come out
  class scan_scoreboard;
    digits_t      codes;
    logic [3:0]   held_err;
    logic         minus;
    logic [1:0]   pos;
    logic [6:0]   seg_lut [16];
    scan_lines_t  lines_q [$];
    int unsigned  fails;

    function new();
      codes    = '0;
      held_err = '0;
      minus    = 1'b0;
      pos      = '0;
      fails    = 0;
      seg_lut  = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h27,
                   7'h7F, 7'h6F, 7'h79, 7'h50, 7'h40, 7'h00, 7'h00, 7'h00};
    endfunction

    // update the mirror with one accepted input transaction
    function void note_input(logic [1:0] action, logic [13:0] value, logic neg,
                             logic [3:0] ecode);
      logic [13:0] v;
      logic [3:0]  shown;
      logic        dot;
      bit          err;
      scan_lines_t r;
      case (action)
        ACT_NUMBER: begin
          if (held_err == '0) begin
            v        = (value > MaxValue) ? MaxValue : value;
            minus    = neg;
            codes[3] = 4'(v / 1000);
            codes[2] = 4'((v % 1000) / 100);
            codes[1] = 4'((v % 100) / 10);
            codes[0] = 4'(v % 10);
          end
        end
        ACT_ERROR: begin
          held_err = ecode;
          codes[3] = CODE_E;
          codes[2] = CODE_R;
          codes[1] = CODE_R;
          codes[0] = (ecode <= 4'd9) ? ecode : CODE_BLANK;
        end
        ACT_TICK: begin
          err = (held_err != '0);
          dot = 1'b0;
          case (pos)
            2'd0: shown = codes[0];
            2'd1: begin
              shown = codes[1];
              dot   = !err;
            end
            2'd2: shown = (codes[3] == '0 && codes[2] == '0) ? CODE_BLANK : codes[2];
            default: begin
              if (minus && !err) shown = CODE_MINUS;
              else if (codes[3] == '0) shown = CODE_BLANK;
              else shown = codes[3];
            end
          endcase
          r.enable   = 4'b0001 << pos;
          r.segments = seg_lut[shown];
          r.point    = dot;
          lines_q.push_back(r);
          pos = pos + 2'd1;
        end
        default: ;
      endcase
    endfunction

    // compare one result transaction with the oldest expected scan lines
    function void check_result(logic [3:0] enable, logic [6:0] segments, logic point);
      scan_lines_t e;
      if (lines_q.size() == 0) begin
        $error("unexpected result: digit_enable %h segments %h point %b",
               enable, segments, point);
        fails++;
      end else begin
        e = lines_q.pop_front();
        if (enable !== e.enable) begin
          $error("digit_enable: expected %h, actual %h", e.enable, enable);
          fails++;
        end
        if (segments !== e.segments) begin
          $error("segments: expected %h, actual %h", e.segments, segments);
          fails++;
        end
        if (point !== e.point) begin
          $error("point: expected %b, actual %b", e.point, point);
          fails++;
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [13:0] value_i;
  logic        negative_i;
  logic [3:0]  error_code_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  digit_enable_o;
  logic [6:0]  segments_o;
  logic        point_o;

  scan_scoreboard sb;

  // idling percentages for the current phase, and the long sink hold-off
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  bit          hold_request;
  int unsigned hold_left;

  seven_segment_scan_driver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .value_i        (value_i),
    .negative_i     (negative_i),
    .error_code_i   (error_code_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digit_enable_o (digit_enable_o),
    .segments_o     (segments_o),
    .point_o        (point_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit, far above the slowest correct run
  initial begin
    #400000;
    $display("tb failed");
    $finish;
  end

  // sink side: random stalls, plus a long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 80;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        sb.check_result(digit_enable_o, segments_o, point_o);
    end
  end

  // offer one transaction and wait for it to be taken
  task automatic send_item(logic [1:0] action, logic [13:0] value, logic neg,
                           logic [3:0] ecode);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= action;
    value_i      <= value;
    negative_i   <= neg;
    error_code_i <= ecode;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(action, value, neg, ecode);
  endtask

  task automatic send_ticks(int unsigned n);
    repeat (n) send_item(ACT_TICK, '0, 1'b0, '0);
  endtask

  // one random transaction, mostly ticks; returns whether the block acts on it
  task automatic random_item(output bit counted);
    int unsigned pick;
    logic [1:0]  act;
    logic [13:0] val;
    logic [3:0]  ec;
    pick = $urandom_range(99);
    val  = 14'($urandom);
    ec   = 4'($urandom);
    if (pick < 60) begin
      act = ACT_TICK;
    end else if (pick < 80) begin
      act = ACT_NUMBER;
      case ($urandom_range(3))
        0: val = 14'($urandom_range(9));
        1: val = 14'($urandom_range(999));
        2: val = 14'($urandom_range(9999));
        default: ;
      endcase
    end else if (pick < 95) begin
      act = ACT_ERROR;
      // clear the hold often so numbers keep getting through
      if ($urandom_range(1)) ec = '0;
    end else begin
      act = 2'd3;
    end
    counted = !(act == 2'd3 || (act == ACT_NUMBER && sb.held_err != '0));
    send_item(act, val, 1'($urandom_range(1)), ec);
  endtask

  initial begin
    int unsigned done;
    bit          counted;
    sb = new();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_request  = 1'b0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    action_i     <= ACT_TICK;
    value_i      <= '0;
    negative_i   <= 1'b0;
    error_code_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset display, saturation, blanking, minus, error hold and release, unused action
    send_ticks(1);
    send_item(ACT_NUMBER, 14'h3FFF, 1'b1, '0);
    send_ticks(4);
    send_item(ACT_NUMBER, 14'd7, 1'b1, '0);
    send_ticks(3);
    send_item(ACT_ERROR, '0, 1'b0, 4'd12);
    send_item(ACT_NUMBER, 14'd1234, 1'b0, '0);
    send_ticks(4);
    send_item(ACT_ERROR, '0, 1'b0, 4'd0);
    send_ticks(4);
    send_item(2'd3, 14'd5, 1'b1, 4'd9);
    send_item(ACT_ERROR, '0, 1'b0, 4'd9);
    send_item(ACT_NUMBER, 14'd105, 1'b0, '0);
    send_item(ACT_ERROR, '0, 1'b0, 4'd0);
    send_item(ACT_NUMBER, 14'd0, 1'b0, '0);
    send_ticks(1);

    // random phases with different idling on each side
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 57; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 57; end
        default: begin
          in_idle_pct   = 7;
          out_stall_pct = 7;
          // sink holds off while the source keeps offering, so the block backs up
          hold_request  = 1'b1;
        end
      endcase
      done = 0;
      while (done < 128) begin
        random_item(counted);
        if (counted) done++;
      end
    end
    in_valid_i <= 1'b0;

    while (sb.lines_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.fails == 0 && sb.lines_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sssd_pkg.sv
rtl/sssd_digit_split.sv
rtl/seven_segment_scan_driver.sv
test/tb.sv
